/* hdl/skvt_pkg.sv */
// Shared constants, codes and types for the sorted key/value table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package skvt_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int CMD_BITS   = 2;
   localparam int STAT_BITS  = 3;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_BITS-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_UPDATED   = 3'd1,
      STAT_REMOVED   = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Operation broadcast to every cell of the chain
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic write_value;
   } op_type;

   // Compare result of one cell against the request key
   typedef struct packed {
      logic above;        // empty or stored key greater than request key
      logic at_or_above;  // occupied and stored key not below request key
      logic match;        // occupied and stored key equal to request key
   } flag_type;

endpackage

`default_nettype wire

/* hdl/skvt_req_if.sv */
// Request channel: valid/ready handshake carrying cmd, key and value.
// Depends on skvt_pkg.
`default_nettype none

interface skvt_req_if import skvt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   cmd;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, cmd, key, value, input ready);
   modport sink   (input valid, cmd, key, value, output ready);
endinterface

`default_nettype wire

/* hdl/skvt_rsp_if.sv */
// Response channel: valid/ready handshake carrying status, found value and count.
// Depends on skvt_pkg.
`default_nettype none

interface skvt_rsp_if import skvt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STAT_BITS-1:0]  status;
   logic [VALUE_BITS-1:0] found_value;
   logic [COUNT_BITS-1:0] entry_count;

   modport source (output valid, status, found_value, entry_count, input ready);
   modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

`default_nettype wire

/* hdl/sorted_key_value_table.sv */
// Sorted key/value table, top level. Depends on skvt_pkg, the channel interfaces and skvt_chain.
// The request is captured first; the response is then registered in the execute state once the
// response register is free. A new request is taken only after that compare-and-shift pass of the chain.
// Reset clears the entry count, the control state and the response valid; stored
// keys and values keep whatever they hold and are never read until written.
`default_nettype none

module sorted_key_value_table import skvt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   skvt_req_if.sink        req_chan,
   skvt_rsp_if.source      rsp_chan
);

   state_type               state_ff, state_in;
   logic [CMD_BITS-1:0]     cmd_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [VALUE_BITS-1:0]   value_ff;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic [VALUE_BITS-1:0]   found_ff, found_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff;

   logic                    req_take;
   logic                    exec;
   logic                    full;
   logic                    hit;
   logic [VALUE_BITS-1:0]   hit_value;
   op_type                  op;

   assign full = (count_ff == COUNT_BITS'(DEPTH));

   always_comb begin
      state_in = state_ff;
      req_take = 1'b0;
      exec     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_take = req_chan.valid;
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Hold until the response register is free
            exec = !rsp_valid_ff || rsp_chan.ready;
            if (exec) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      op        = '0;
      status_in = STAT_NOT_FOUND;
      found_in  = '0;
      count_in  = count_ff;
      case (cmd_ff)
         CMD_LOOKUP: begin
            if (hit) begin
               status_in = STAT_FOUND;
               found_in  = hit_value;
            end
         end
         CMD_INSERT: begin
            if (hit) begin
               status_in      = STAT_UPDATED;
               op.write_value = exec;
            end else if (full) begin
               status_in = STAT_FULL;
            end else begin
               status_in   = STAT_INSERTED;
               op.shift_up = exec;
               count_in    = count_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               status_in     = STAT_REMOVED;
               op.shift_down = exec;
               count_in      = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STAT_NOT_FOUND;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   skvt_chain u_chain (
      .clock     (clock),
      .count     (count_ff),
      .req_key   (key_ff),
      .req_value (value_ff),
      .op        (op),
      .hit       (hit),
      .hit_value (hit_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= req_chan.cmd;
         key_ff   <= req_chan.key;
         value_ff <= req_chan.value;
      end
      if (exec) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.found_value = found_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("entry count beyond table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      exec && status_in == STAT_INSERTED |=> count_ff == COUNT_BITS'($past(count_ff) + 1'b1))
      else $error("insert did not grow the table by one");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      exec && status_in == STAT_REMOVED |=> count_ff == COUNT_BITS'($past(count_ff) - 1'b1))
      else $error("remove did not shrink the table by one");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      exec && status_in == STAT_FULL |-> count_ff == COUNT_BITS'(DEPTH))
      else $error("full reported on a table with room");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> !req_chan.ready)
      else $error("request taken while one is in progress");
`endif

endmodule

`default_nettype wire

/* hdl/skvt_cell.sv */
// One slot of the sorted chain: holds a key/value pair, compares it with the
// request key and takes data from a neighbour or the request on insert, remove or update. Uses skvt_pkg.
`default_nettype none

module skvt_cell import skvt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  occupied,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire op_type                op,
   input  wire logic                  left_above,
   input  wire logic [KEY_BITS-1:0]   left_key,
   input  wire logic [VALUE_BITS-1:0] left_value,
   input  wire logic [KEY_BITS-1:0]   right_key,
   input  wire logic [VALUE_BITS-1:0] right_value,
   output flag_type                   flags,
   output logic [KEY_BITS-1:0]        key_q,
   output logic [VALUE_BITS-1:0]      value_q
);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   always_comb begin
      flags.above       = !occupied || (key_ff > req_key);
      flags.at_or_above = occupied && (key_ff >= req_key);
      flags.match       = occupied && (key_ff == req_key);
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (op.shift_up) begin
         // Everything above the insertion point moves up one slot
         if (left_above) begin
            key_in   = left_key;
            value_in = left_value;
         end else if (flags.above) begin
            key_in   = req_key;
            value_in = req_value;
         end
      end else if (op.shift_down) begin
         if (flags.at_or_above) begin
            key_in   = right_key;
            value_in = right_value;
         end
      end else if (op.write_value && flags.match) begin
         value_in = req_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_q   = key_ff;
   assign value_q = value_ff;

endmodule

`default_nettype wire

/* hdl/skvt_chain.sv */
// Row of DEPTH cells with neighbour links, plus hit detection and value read-out.
// Depends on skvt_pkg and skvt_cell.
`default_nettype none

module skvt_chain import skvt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [COUNT_BITS-1:0] count,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire op_type                op,
   output logic                       hit,
   output logic [VALUE_BITS-1:0]      hit_value
);

   flag_type              flags  [DEPTH];
   logic [KEY_BITS-1:0]   keys   [DEPTH];
   logic [VALUE_BITS-1:0] values [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                  left_above;
      logic [KEY_BITS-1:0]   left_key;
      logic [VALUE_BITS-1:0] left_value;
      logic [KEY_BITS-1:0]   right_key;
      logic [VALUE_BITS-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_above = 1'b0;
         assign left_key   = keys[g];
         assign left_value = values[g];
      end else begin : g_inner_left
         assign left_above = flags[g-1].above;
         assign left_key   = keys[g-1];
         assign left_value = values[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_key   = keys[g];
         assign right_value = values[g];
      end else begin : g_inner_right
         assign right_key   = keys[g+1];
         assign right_value = values[g+1];
      end

      skvt_cell u_cell (
         .clock       (clock),
         .occupied    (COUNT_BITS'(g) < count),
         .req_key     (req_key),
         .req_value   (req_value),
         .op          (op),
         .left_above  (left_above),
         .left_key    (left_key),
         .left_value  (left_value),
         .right_key   (right_key),
         .right_value (right_value),
         .flags       (flags[g]),
         .key_q       (keys[g]),
         .value_q     (values[g])
      );
   end

   // At most one cell matches, so an OR of gated values reads it out
   always_comb begin
      hit       = 1'b0;
      hit_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit       = hit | flags[i].match;
         hit_value = hit_value | (flags[i].match ? values[i] : '0);
      end
   end

endmodule

`default_nettype wire
